### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the grid local maximum detector.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define GLMD_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define GLMD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GLMD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/glmd_pkg.sv
// ----------------------------------------------------------------------------
// glmd_pkg
// Types and constants shared by the grid local maximum detector modules.
// ----------------------------------------------------------------------------
`default_nettype none

package glmd_pkg;

	// Width of the frame size registers and of the reported coordinates.
	localparam int CFG_W = 8;
	localparam int POS_W = 7;

	localparam logic [CFG_W-1:0] DIM_RESET = 8'd128;

	typedef enum logic [0:0] {
		REG_ROW_COUNT    = 1'b0,
		REG_COLUMN_COUNT = 1'b1
	} glmd_reg_t;

	// Cells decided by one request, in reporting order.
	typedef struct packed {
		logic upper;   // cell above the new value
		logic left;    // last-row cell left of the new value
		logic corner;  // final cell of the frame
	} glmd_hits_t;

endpackage

`default_nettype wire

### rtl/glmd_cell.sv
// ----------------------------------------------------------------------------
// glmd_cell
// One storage cell of a line buffer chain: takes the new value at the tail,
// otherwise the value of its neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module glmd_cell #(
	parameter int VW = 16
) (
	input  logic          clk,
	input  logic          en,
	input  logic          tail,
	input  logic [VW-1:0] src,
	input  logic [VW-1:0] nxt,
	output logic [VW-1:0] q
);

	logic [VW-1:0] data_q;

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= tail ? src : nxt;
		end
	end

	assign q = data_q;

endmodule

`default_nettype wire

### rtl/glmd_chain.sv
// ----------------------------------------------------------------------------
// glmd_chain
// Row of cells forming a delay line whose length is chosen at run time.
// ----------------------------------------------------------------------------
`default_nettype none

module glmd_chain #(
	parameter int VW    = 16,
	parameter int DEPTH = 128,
	localparam int LW   = $clog2(DEPTH + 1)
) (
	input  logic          clk,
	input  logic          en,
	input  logic [LW-1:0] len,
	input  logic [VW-1:0] din,
	output logic [VW-1:0] dout
);

	logic [VW-1:0] tap [DEPTH];

	// New data enters at cell len-1 and walks one cell toward cell 0 per
	// request, so cell 0 shows the value taken len requests ago.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic          tail;
		logic [VW-1:0] nxt;

		if (i == DEPTH - 1) begin : g_end
			assign tail = 1'b1;
			assign nxt  = din;
		end else begin : g_mid
			assign tail = (len == LW'(i + 1));
			assign nxt  = tap[i+1];
		end

		glmd_cell #(
			.VW (VW)
		) u_cell (
			.clk  (clk),
			.en   (en),
			.tail (tail),
			.src  (din),
			.nxt  (nxt),
			.q    (tap[i])
		);
	end

	assign dout = tap[0];

endmodule

`default_nettype wire

### rtl/glmd_out_queue.sv
// ----------------------------------------------------------------------------
// glmd_out_queue
// Holds the results decided by one request and hands them out one per cycle
// through an output register while the output is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module glmd_out_queue import glmd_pkg::*; #(
	parameter int VW = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  glmd_hits_t           hits,
	input  logic [POS_W-1:0]     row_in,
	input  logic [POS_W-1:0]     col_in,
	input  logic signed [VW-1:0] val_upper,
	input  logic signed [VW-1:0] val_left,
	input  logic signed [VW-1:0] val_corner,
	output logic                 can_load,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [VW-1:0] peak_value,
	output logic [POS_W-1:0]     peak_row,
	output logic [POS_W-1:0]     peak_column,
	output logic                 last_of_run
);

	glmd_hits_t            hits_s1;
	logic [POS_W-1:0]      row_s1;
	logic [POS_W-1:0]      col_s1;
	logic signed [VW-1:0]  upper_s1;
	logic signed [VW-1:0]  left_s1;
	logic signed [VW-1:0]  corner_s1;

	logic                  out_valid_q;
	logic signed [VW-1:0]  value_q;
	logic [POS_W-1:0]      row_q;
	logic [POS_W-1:0]      col_q;
	logic                  last_q;

	logic                  pending;
	logic                  slot_free;
	logic                  move;
	glmd_hits_t            rest;
	logic signed [VW-1:0]  sel_value;
	logic [POS_W-1:0]      sel_row;
	logic [POS_W-1:0]      sel_col;

	assign pending   = hits_s1.upper | hits_s1.left | hits_s1.corner;
	assign slot_free = !out_valid_q || out_ready;
	assign move      = pending && slot_free;

	// A new request may enter once the held results will all have moved on.
	assign can_load  = !pending || ($onehot(hits_s1) && slot_free);

	always_comb begin
		rest      = hits_s1;
		sel_value = corner_s1;
		sel_row   = row_s1;
		sel_col   = col_s1;
		priority if (hits_s1.upper) begin
			rest.upper = 1'b0;
			sel_value  = upper_s1;
			sel_row    = row_s1 - POS_W'(1);
		end else if (hits_s1.left) begin
			rest.left  = 1'b0;
			sel_value  = left_s1;
			sel_col    = col_s1 - POS_W'(1);
		end else begin
			rest.corner = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_s1     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				hits_s1 <= hits;
			end else if (move) begin
				hits_s1 <= rest;
			end
			if (slot_free) begin
				out_valid_q <= move;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			row_s1    <= row_in;
			col_s1    <= col_in;
			upper_s1  <= val_upper;
			left_s1   <= val_left;
			corner_s1 <= val_corner;
		end
		if (move) begin
			value_q <= sel_value;
			row_q   <= sel_row;
			col_q   <= sel_col;
			last_q  <= (rest == '0);
		end
	end

	assign out_valid   = out_valid_q;
	assign peak_value  = value_q;
	assign peak_row    = row_q;
	assign peak_column = col_q;
	assign last_of_run = last_q;

	`GLMD_ASSERT_IMPL(a_load_when_drained, clk, arst_n, load,
		$countones(hits_s1) == 0 || ($countones(hits_s1) == 1 && slot_free),
		"request taken while earlier results were still held")
	`GLMD_ASSERT_NEXT(a_run_continues, clk, arst_n,
		out_valid_q && out_ready && !last_q, out_valid_q,
		"gap inside a run of results")
	`GLMD_ASSERT_NEXT(a_held_when_blocked, clk, arst_n,
		pending && !slot_free, $stable(hits_s1),
		"held results changed while the output was stalled")

endmodule

`default_nettype wire

### rtl/grid_local_maximum_detector_top.sv
// ----------------------------------------------------------------------------
// grid_local_maximum_detector_top
// Four-neighbor local maximum detection over a grid streamed in raster order.
//
//   Channel   Direction  Handshake              Payload
//   input     in         in_valid / in_ready    cell_value
//   output    out        out_valid / out_ready  peak_value, peak_row,
//                                               peak_column, last_of_run
//   config    in         cfg_we                 cfg_index, cfg_data
//
// One request is taken per cycle while it decides at most one peak and the
// output is not stalled; results leave one per cycle unless stalled, so a
// request that decides two or three peaks holds the input until its extra
// peaks have moved on. The line buffers are chains of cells shifting once per
// request. Reset sets both frame sizes to 128 and the frame position to zero;
// there is no clearing pass. A configuration write also restarts the frame.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module grid_local_maximum_detector_top import glmd_pkg::*; #(
	parameter int MAX_DIM     = 128,
	parameter int VALUE_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [0:0]                    cfg_index,
	input  logic [CFG_W-1:0]              cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [VALUE_WIDTH-1:0] cell_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [VALUE_WIDTH-1:0] peak_value,
	output logic [POS_W-1:0]              peak_row,
	output logic [POS_W-1:0]              peak_column,
	output logic                          last_of_run
);

	localparam int DW = $clog2(MAX_DIM + 1);
	localparam int AW = $clog2(MAX_DIM);
	localparam int CW = (DW > CFG_W) ? DW : CFG_W;
	localparam int VW = VALUE_WIDTH;

	function automatic logic [DW-1:0] clamp_dim(input logic [CFG_W-1:0] v);
		logic [CW-1:0] ext;
		ext = CW'(v);
		if (ext == '0) begin
			return DW'(1);
		end else if (ext > CW'(MAX_DIM)) begin
			return DW'(MAX_DIM);
		end
		return DW'(ext);
	endfunction

	logic [CFG_W-1:0]     row_count_q;
	logic [CFG_W-1:0]     col_count_q;
	logic [AW-1:0]        row_q;
	logic [AW-1:0]        col_q;

	// Neighborhood window: above, above-left, and the two previous values.
	logic signed [VW-1:0] up_q;
	logic signed [VW-1:0] up_left_q;
	logic signed [VW-1:0] left1_q;
	logic signed [VW-1:0] left2_q;

	logic [DW-1:0]        rows;
	logic [DW-1:0]        cols;
	logic                 accept;
	logic                 row_last;
	logic                 col_last;
	logic                 single_col;
	logic [AW-1:0]        len_a;
	logic signed [VW-1:0] up_right;
	logic signed [VW-1:0] up_up;
	glmd_hits_t           hits;

	assign rows       = clamp_dim(row_count_q);
	assign cols       = clamp_dim(col_count_q);
	assign accept     = in_valid && in_ready;
	assign row_last   = (DW'(row_q) == rows - DW'(1));
	assign col_last   = (DW'(col_q) == cols - DW'(1));
	assign single_col = (cols == DW'(1));
	assign len_a      = single_col ? AW'(1) : AW'(cols - DW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= DIM_RESET;
			col_count_q <= DIM_RESET;
			row_q       <= '0;
			col_q       <= '0;
		end else if (cfg_we) begin
			unique case (glmd_reg_t'(cfg_index))
				REG_ROW_COUNT:    row_count_q <= cfg_data;
				REG_COLUMN_COUNT: col_count_q <= cfg_data;
			endcase
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_q + AW'(1);
			end else begin
				col_q <= col_q + AW'(1);
			end
		end
	end

	// Chain A delays by cols-1 requests (the cell above and to the right);
	// chain B delays the cell-above value by another cols requests.
	glmd_chain #(
		.VW    (VW),
		.DEPTH (MAX_DIM - 1)
	) u_chain_a (
		.clk  (clk),
		.en   (accept),
		.len  (len_a),
		.din  (cell_value),
		.dout (up_right)
	);

	glmd_chain #(
		.VW    (VW),
		.DEPTH (MAX_DIM)
	) u_chain_b (
		.clk  (clk),
		.en   (accept),
		.len  (cols),
		.din  (up_q),
		.dout (up_up)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			up_q      <= single_col ? cell_value : up_right;
			up_left_q <= up_q;
			left2_q   <= left1_q;
			left1_q   <= cell_value;
		end
	end

	// Ties count as maxima, so a neighbor only rules a cell out when larger.
	always_comb begin
		hits.upper  = (row_q != '0)
			&& !((row_q > AW'(1)) && (up_q < up_up))
			&& !(up_q < cell_value)
			&& !((col_q != '0) && (up_q < up_left_q))
			&& !(!col_last && (up_q < up_right));
		hits.left   = row_last && (col_q != '0)
			&& !((row_q != '0) && (left1_q < up_left_q))
			&& !((col_q > AW'(1)) && (left1_q < left2_q))
			&& !(left1_q < cell_value);
		hits.corner = row_last && col_last
			&& !((row_q != '0) && (cell_value < up_q))
			&& !((col_q != '0) && (cell_value < left1_q));
	end

	glmd_out_queue #(
		.VW (VW)
	) u_out_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (accept),
		.hits        (hits),
		.row_in      (POS_W'(row_q)),
		.col_in      (POS_W'(col_q)),
		.val_upper   (up_q),
		.val_left    (left1_q),
		.val_corner  (cell_value),
		.can_load    (in_ready),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.peak_value  (peak_value),
		.peak_row    (peak_row),
		.peak_column (peak_column),
		.last_of_run (last_of_run)
	);

	`GLMD_ASSERT_ALWAYS(a_pos_in_frame, clk, arst_n,
		DW'(row_q) < rows && DW'(col_q) < cols,
		"frame position outside the configured grid")
	`GLMD_ASSERT_NEXT(a_frame_wraps, clk, arst_n,
		accept && row_last && col_last, row_q == '0 && col_q == '0,
		"frame did not restart after its final cell")

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Streams grid values into the four-neighbor local maximum detector under
// random input gaps and output stalls. A scoreboard tracks the frame
// position and line buffers itself, predicts the peaks that each accepted
// request decides, and compares every result field by field in arrival order.
// ----------------------------------------------------------------------------

module tb_top;
	import glmd_pkg::*;

	localparam int GRID_MAX = 128;
	localparam int VAL_W    = 16;

	typedef struct {
		logic signed [VAL_W-1:0] value;
		logic [POS_W-1:0]        row;
		logic [POS_W-1:0]        col;
		logic                    last;
	} peak_t;

	// Opens with a 3x4 frame, then a 1x1 frame written as zero sizes,
	// a single row and a single column.
	localparam logic signed [VAL_W-1:0] DIRECTED_CELLS [22] = '{
		16'sh7FFF, 16'sd5, 16'sh8000, 16'sd0,
		16'sd7, 16'sd7, -16'sd1, 16'sd100,
		16'sh8000, 16'sd7, 16'sd100, 16'sd100,
		16'sh8000, 16'sh7FFF,
		16'sd3, 16'sd3, -16'sd1, 16'sh7FFF,
		16'sd1, 16'sd2, 16'sd2, -16'sd7
	};

	class peak_tracker;
		logic [CFG_W-1:0]        row_reg = DIM_RESET;
		logic [CFG_W-1:0]        col_reg = DIM_RESET;
		logic signed [VAL_W-1:0] line_buf [2][GRID_MAX];
		logic signed [VAL_W-1:0] left_last;
		logic signed [VAL_W-1:0] left_prev;
		int                      row_at;
		int                      col_at;
		peak_t                   pending_peaks [$];
		int                      errors;

		function int clamp_size(logic [CFG_W-1:0] size);
			if (size == 0)
				return 1;
			if (size > GRID_MAX)
				return GRID_MAX;
			return size;
		endfunction

		function void write_size(glmd_reg_t idx, logic [CFG_W-1:0] data);
			if (idx == REG_ROW_COUNT)
				row_reg = data;
			else
				col_reg = data;
			row_at = 0;
			col_at = 0;
		endfunction

		function void add_peak(logic signed [VAL_W-1:0] value, int row, int col);
			peak_t p;
			p.value = value;
			p.row   = POS_W'(row);
			p.col   = POS_W'(col);
			p.last  = 1'b0;
			pending_peaks.push_back(p);
		endfunction

		function void take_cell(logic signed [VAL_W-1:0] v);
			int                      rows;
			int                      cols;
			int                      r;
			int                      c;
			int                      first;
			logic signed [VAL_W-1:0] cur;
			bit                      is_peak;
			rows  = clamp_size(row_reg);
			cols  = clamp_size(col_reg);
			r     = row_at;
			c     = col_at;
			first = pending_peaks.size();
			if (r >= rows || c >= cols) begin
				r = 0;
				c = 0;
			end
			// The new value completes the neighborhood of the cell above it.
			if (r >= 1) begin
				cur     = line_buf[(r - 1) % 2][c];
				is_peak = 1'b1;
				if (r >= 2 && cur < line_buf[r % 2][c])
					is_peak = 1'b0;
				if (cur < v)
					is_peak = 1'b0;
				if (c > 0 && cur < line_buf[(r - 1) % 2][c - 1])
					is_peak = 1'b0;
				if (c + 1 < cols && cur < line_buf[(r - 1) % 2][c + 1])
					is_peak = 1'b0;
				if (is_peak)
					add_peak(cur, r - 1, c);
			end
			line_buf[r % 2][c] = v;
			if (r == rows - 1) begin
				if (c > 0) begin
					is_peak = 1'b1;
					if (r > 0 && left_last < line_buf[(r - 1) % 2][c - 1])
						is_peak = 1'b0;
					if (c >= 2 && left_last < left_prev)
						is_peak = 1'b0;
					if (left_last < v)
						is_peak = 1'b0;
					if (is_peak)
						add_peak(left_last, r, c - 1);
				end
				if (c == cols - 1) begin
					is_peak = 1'b1;
					if (r > 0 && v < line_buf[(r - 1) % 2][c])
						is_peak = 1'b0;
					if (c > 0 && v < left_last)
						is_peak = 1'b0;
					if (is_peak)
						add_peak(v, r, c);
				end
			end
			left_prev = left_last;
			left_last = v;
			c++;
			if (c >= cols) begin
				c = 0;
				r++;
				if (r >= rows)
					r = 0;
			end
			row_at = r;
			col_at = c;
			if (pending_peaks.size() > first)
				pending_peaks[$].last = 1'b1;
		endfunction

		function void report_field(string name, int want, int got);
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		endfunction

		function void match_peak(logic signed [VAL_W-1:0] value, logic [POS_W-1:0] row,
				logic [POS_W-1:0] col, logic last);
			peak_t want;
			if (pending_peaks.size() == 0) begin
				errors++;
				$display("%0t: unexpected peak, expected none, actual value %0d row %0d column %0d",
					$time, value, row, col);
				return;
			end
			want = pending_peaks.pop_front();
			if (value !== want.value)
				report_field("peak_value", want.value, value);
			if (row !== want.row)
				report_field("peak_row", want.row, row);
			if (col !== want.col)
				report_field("peak_column", want.col, col);
			if (last !== want.last)
				report_field("last_of_run", want.last, last);
		endfunction

		function int pending();
			return pending_peaks.size();
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [0:0]              cfg_index;
	logic [CFG_W-1:0]        cfg_data;
	logic                    in_valid;
	logic                    in_ready;
	logic signed [VAL_W-1:0] cell_value;
	logic                    out_valid;
	logic                    out_ready;
	logic signed [VAL_W-1:0] peak_value;
	logic [POS_W-1:0]        peak_row;
	logic [POS_W-1:0]        peak_column;
	logic                    last_of_run;

	peak_tracker tracker = new();
	int          items_sent;
	bit          tail_phase;

	grid_local_maximum_detector_top #(
		.MAX_DIM     (GRID_MAX),
		.VALUE_WIDTH (VAL_W)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cell_value  (cell_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.peak_value  (peak_value),
		.peak_row    (peak_row),
		.peak_column (peak_column),
		.last_of_run (last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Handshakes are sampled at the falling edge, where every signal already
	// holds the value that the next rising edge will see.
	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.match_peak(peak_value, peak_row, peak_column, last_of_run);
	end

	initial begin
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!tail_phase && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	initial begin
		#3_000_000;
		$display("** grid_local_maximum_detector_top: FAILED **");
		$finish;
	end

	function automatic logic signed [VAL_W-1:0] random_cell();
		case ($urandom_range(0, 9))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2, 3, 4: return VAL_W'($urandom);
			default: return VAL_W'($urandom_range(0, 4)) - 16'd2;
		endcase
	endfunction

	task automatic send_cell(input logic signed [VAL_W-1:0] v);
		if (!tail_phase && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		cell_value <= v;
		do @(negedge clk); while (!in_ready);
		tracker.take_cell(v);
		@(posedge clk);
		items_sent++;
	endtask

	// Waits until every predicted peak has left the block, then lets requests
	// that decided nothing settle too.
	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_frame(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= REG_ROW_COUNT;
		cfg_data  <= rows;
		@(posedge clk);
		tracker.write_size(REG_ROW_COUNT, rows);
		cfg_index <= REG_COLUMN_COUNT;
		cfg_data  <= cols;
		@(posedge clk);
		tracker.write_size(REG_COLUMN_COUNT, cols);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [CFG_W-1:0] rows;
		logic [CFG_W-1:0] cols;
		int               frame;
		int               count;
		arst_n     <= 1'b0;
		cfg_we     <= 1'b0;
		cfg_index  <= REG_ROW_COUNT;
		cfg_data   <= '0;
		in_valid   <= 1'b0;
		cell_value <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 22; i++) begin
			case (i)
				0: set_frame(8'd3, 8'd4);
				12: set_frame(8'd0, 8'd0);
				14: set_frame(8'd1, 8'd4);
				18: set_frame(8'd4, 8'd1);
				default: ;
			endcase
			send_cell(DIRECTED_CELLS[i]);
		end

		// Sizes above the limit clamp, so these reach the largest row and column.
		set_frame(8'd255, 8'd1);
		repeat (GRID_MAX) send_cell(random_cell());
		set_frame(8'd1, 8'd200);
		repeat (GRID_MAX) send_cell(random_cell());

		// Mostly whole frames; some end with a partial frame that the next
		// size write cuts off.
		while (items_sent < 460) begin
			rows  = ($urandom_range(0, 9) == 0) ? 8'd0 : CFG_W'($urandom_range(1, 6));
			cols  = ($urandom_range(0, 9) == 0) ? 8'd0 : CFG_W'($urandom_range(1, 8));
			frame = tracker.clamp_size(rows) * tracker.clamp_size(cols);
			count = frame * $urandom_range(1, 2);
			if ($urandom_range(0, 3) == 0)
				count += $urandom_range(1, frame);
			if (items_sent >= 400)
				tail_phase = 1'b1;
			set_frame(rows, cols);
			repeat (count) send_cell(random_cell());
		end

		drain();
		repeat (8) @(posedge clk);
		if (tracker.errors == 0)
			$display("** grid_local_maximum_detector_top: PASSED **");
		else
			$display("** grid_local_maximum_detector_top: FAILED **");
		$finish;
	end

endmodule

### files.f
+incdir+rtl
rtl/glmd_pkg.sv
rtl/glmd_cell.sv
rtl/glmd_chain.sv
rtl/glmd_out_queue.sv
rtl/grid_local_maximum_detector_top.sv
tb/tb_top.sv
